>>> src/lpu_pkg.sv
// Shared constants, types and fixed-point helpers of the lens point undistortion block.
package lpu_pkg;

    localparam int LPU_ITERATIONS = 20;
    localparam int QW             = 32;
    localparam int DIV_STEPS      = QW;
    localparam int DIV_LAT        = DIV_STEPS + 2;
    localparam int ITER_LAT       = 10;
    localparam int OUT_LAT        = 3;
    localparam int CFG_IW         = 8;
    localparam int CFG_DW         = 32;

    localparam logic signed [63:0] Q_ONE  = 64'sd268435456;
    localparam logic signed [63:0] Q_HALF = 64'sd134217728;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [17:0] S18_MIN = 18'sh20000;
    localparam logic signed [17:0] S18_MAX = 18'sh1ffff;

    localparam logic [17:0] FOCAL_RESET = 18'd16384;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PRINCIPAL = 8'd0,
        CFG_FOCAL_X   = 8'd1,
        CFG_FOCAL_Y   = 8'd2,
        CFG_K1        = 8'd3,
        CFG_K2        = 8'd4,
        CFG_K3        = 8'd5,
        CFG_P1        = 8'd6,
        CFG_P2        = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } coef_t;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] xd0;
        logic signed [31:0] xd1;
        logic               clip;
    } pt_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    typedef struct packed {
        logic               clip;
        logic signed [17:0] val;
    } sat18_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v[63:31] == '0 || v[63:31] == '1)
        begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        else
        begin
            r.clip = 1'b1;
            r.val  = v[63] ? S32_MIN : S32_MAX;
        end
        return r;
    endfunction

    // floor((p + 2^27) / 2^28), then saturate
    function automatic sat_t rnd28(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + Q_HALF;
        return sat32(t >>> 28);
    endfunction

    function automatic sat18_t sat18(input logic signed [24:0] v);
        sat18_t r;
        if (v[24:17] == '0 || v[24:17] == '1)
        begin
            r.clip = 1'b0;
            r.val  = v[17:0];
        end
        else
        begin
            r.clip = 1'b1;
            r.val  = v[24] ? S18_MIN : S18_MAX;
        end
        return r;
    endfunction

endpackage

>>> src/lpu_if.sv
// Stream interfaces for observed input points and undistorted result points.
interface lpu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] observed_x;
    logic [15:0] observed_y;

    modport source (output valid, output observed_x, output observed_y, input ready);
    modport sink (input valid, input observed_x, input observed_y, output ready);
endinterface

interface lpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] ideal_x;
    logic signed [17:0] ideal_y;
    logic               clipped;

    modport source (output valid, output ideal_x, output ideal_y, output clipped, input ready);
    modport sink (input valid, input ideal_x, input ideal_y, input clipped, output ready);
endinterface

>>> src/lpu_div.sv
// Two-lane pipelined restoring divider: round(n * 2^28 / d), saturated, one quotient bit a stage.
module lpu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [32:0] n0,
    input  logic signed [32:0] n1,
    input  logic signed [32:0] d0,
    input  logic signed [32:0] d1,
    output logic               out_valid,
    output logic signed [31:0] q0,
    output logic signed [31:0] q1,
    output logic               clipped
);
    import lpu_pkg::*;

    typedef struct packed {
        logic        zero;
        logic        nzero;
        logic        nsign;
        logic        neg;
        logic        big;
        logic [32:0] dd;
        logic [32:0] rem;
        logic [31:0] w;
    } lane_t;

    function automatic lane_t lane_pre(input logic signed [32:0] n, input logic signed [32:0] d);
        lane_t       l;
        logic [32:0] an;
        logic [32:0] ad;
        logic [60:0] nn;
        an      = n[32] ? 33'(-n) : 33'(n);
        ad      = d[32] ? 33'(-d) : 33'(d);
        nn      = {an[31:0], 29'b0} + 61'(ad[31:0]);
        l.zero  = (d == '0);
        l.nzero = (n == '0);
        l.nsign = n[32];
        l.neg   = n[32] ^ d[32];
        l.dd    = {ad[31:0], 1'b0};
        l.big   = (33'(nn[60:32]) >= l.dd);
        l.rem   = 33'(nn[60:32]);
        l.w     = nn[31:0];
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t li);
        lane_t       l;
        logic [33:0] t;
        logic        qb;
        l  = li;
        t  = {li.rem, li.w[31]};
        qb = (t >= {1'b0, li.dd});
        if (qb)
        begin
            t = t - {1'b0, li.dd};
        end
        l.rem = t[32:0];
        l.w   = {li.w[30:0], qb};
        return l;
    endfunction

    function automatic sat_t lane_post(input lane_t l);
        sat_t r;
        r.clip = 1'b0;
        r.val  = $signed(l.w);
        if (l.zero)
        begin
            r.clip = 1'b1;
            r.val  = l.nzero ? '0 : (l.nsign ? S32_MIN : S32_MAX);
        end
        else if (l.big)
        begin
            r.clip = 1'b1;
            r.val  = l.neg ? S32_MIN : S32_MAX;
        end
        else if (l.neg)
        begin
            if (l.w > 32'h80000000)
            begin
                r.clip = 1'b1;
                r.val  = S32_MIN;
            end
            else
            begin
                r.val = $signed(32'(-l.w));
            end
        end
        else if (l.w[31])
        begin
            r.clip = 1'b1;
            r.val  = S32_MAX;
        end
        return r;
    endfunction

    logic [DIV_STEPS:0] v_reg;
    lane_t              l0_reg [0:DIV_STEPS];
    lane_t              l1_reg [0:DIV_STEPS];
    logic               out_valid_reg;
    logic signed [31:0] q0_reg;
    logic signed [31:0] q1_reg;
    logic               clip_reg;
    sat_t               r0_next;
    sat_t               r1_next;

    always_comb
    begin
        r0_next = lane_post(l0_reg[DIV_STEPS]);
        r1_next = lane_post(l1_reg[DIV_STEPS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[DIV_STEPS-1:0], in_valid};
            out_valid_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l0_reg[0] <= lane_pre(n0, d0);
            l1_reg[0] <= lane_pre(n1, d1);
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                l0_reg[k] <= lane_step(l0_reg[k-1]);
                l1_reg[k] <= lane_step(l1_reg[k-1]);
            end
            q0_reg   <= r0_next.val;
            q1_reg   <= r1_next.val;
            clip_reg <= r0_next.clip | r1_next.clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign q0        = q0_reg;
    assign q1        = q1_reg;
    assign clipped   = clip_reg;

endmodule

>>> src/lpu_iter.sv
// One undistortion iteration: radial and tangential terms over ten stages, then the divider.
module lpu_iter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  lpu_pkg::coef_t coef,
    input  logic          in_valid,
    input  lpu_pkg::pt_t  in_pt,
    output logic          out_valid,
    output lpu_pkg::pt_t  out_pt
);
    import lpu_pkg::*;

    typedef struct packed {
        logic signed [31:0] xd0;
        logic signed [31:0] xd1;
        logic               clip;
    } side_t;

    logic [ITER_LAT-1:0] v_reg;
    side_t               sd_reg  [0:ITER_LAT-1];
    side_t               dly_reg [0:DIV_LAT-1];

    logic signed [63:0] p00_reg, p11_reg, p01_reg;
    logic signed [31:0] s0_2_reg, s1_2_reg, c_2_reg;
    logic signed [31:0] r2_3_reg, s0_3_reg, s1_3_reg, c_3_reg;
    logic signed [63:0] pr4_4_reg, pk1_4_reg, pp1c_4_reg, pp2c_4_reg;
    logic signed [31:0] t0_4_reg, t1_4_reg, r2_4_reg;
    logic signed [31:0] r4_5_reg, m1_5_reg, a1_5_reg, a2_5_reg, r2_5_reg;
    logic signed [63:0] pp2t0_5_reg, pp1t1_5_reg;
    logic signed [63:0] pr6_6_reg, pk2_6_reg;
    logic signed [31:0] b0_6_reg, b1_6_reg, m1_6_reg, a1_6_reg, a2_6_reg;
    logic signed [31:0] r6_7_reg, m2_7_reg, dx0_7_reg, dx1_7_reg, m1_7_reg;
    logic signed [63:0] pk3_8_reg;
    logic signed [31:0] n0_8_reg, n1_8_reg, m1_8_reg, m2_8_reg;
    logic signed [31:0] m3_9_reg, n0_9_reg, n1_9_reg, m1_9_reg, m2_9_reg;
    logic signed [31:0] kr_10_reg, n0_10_reg, n1_10_reg;

    sat_t s0_next, s1_next, c_next, r2_next, t0_next, t1_next;
    sat_t r4_next, m1_next, a1_next, a2_next, r6_next, m2_next, b0_next, b1_next;
    sat_t dx0_next, dx1_next, n0_next, n1_next, m3_next, kr_next;

    logic               div_valid;
    logic signed [31:0] div_q0;
    logic signed [31:0] div_q1;
    logic               div_clip;

    always_comb
    begin
        s0_next  = rnd28(p00_reg);
        s1_next  = rnd28(p11_reg);
        c_next   = rnd28(p01_reg);
        r2_next  = sat32(64'(s0_2_reg) + 64'(s1_2_reg));
        t0_next  = sat32(64'(r2_3_reg) + (64'(s0_3_reg) <<< 1));
        t1_next  = sat32(64'(r2_3_reg) + (64'(s1_3_reg) <<< 1));
        r4_next  = rnd28(pr4_4_reg);
        m1_next  = rnd28(pk1_4_reg);
        a1_next  = rnd28(pp1c_4_reg);
        a2_next  = rnd28(pp2c_4_reg);
        b0_next  = rnd28(pp2t0_5_reg);
        b1_next  = rnd28(pp1t1_5_reg);
        r6_next  = rnd28(pr6_6_reg);
        m2_next  = rnd28(pk2_6_reg);
        dx0_next = sat32((64'(a1_6_reg) <<< 1) + 64'(b0_6_reg));
        dx1_next = sat32(64'(b1_6_reg) + (64'(a2_6_reg) <<< 1));
        n0_next  = sat32(64'(sd_reg[6].xd0) - 64'(dx0_7_reg));
        n1_next  = sat32(64'(sd_reg[6].xd1) - 64'(dx1_7_reg));
        m3_next  = rnd28(pk3_8_reg);
        kr_next  = sat32(Q_ONE + 64'(m1_9_reg) + 64'(m2_9_reg) + 64'(m3_9_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ITER_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: squares and cross product
            p00_reg      <= 64'(in_pt.x0) * 64'(in_pt.x0);
            p11_reg      <= 64'(in_pt.x1) * 64'(in_pt.x1);
            p01_reg      <= 64'(in_pt.x0) * 64'(in_pt.x1);
            sd_reg[0]    <= '{xd0: in_pt.xd0, xd1: in_pt.xd1, clip: in_pt.clip};
            // stage 2
            s0_2_reg     <= s0_next.val;
            s1_2_reg     <= s1_next.val;
            c_2_reg      <= c_next.val;
            sd_reg[1]    <= '{xd0: sd_reg[0].xd0, xd1: sd_reg[0].xd1,
                              clip: sd_reg[0].clip | s0_next.clip | s1_next.clip | c_next.clip};
            // stage 3
            r2_3_reg     <= r2_next.val;
            s0_3_reg     <= s0_2_reg;
            s1_3_reg     <= s1_2_reg;
            c_3_reg      <= c_2_reg;
            sd_reg[2]    <= '{xd0: sd_reg[1].xd0, xd1: sd_reg[1].xd1,
                              clip: sd_reg[1].clip | r2_next.clip};
            // stage 4
            pr4_4_reg    <= 64'(r2_3_reg) * 64'(r2_3_reg);
            pk1_4_reg    <= 64'(coef.k1) * 64'(r2_3_reg);
            pp1c_4_reg   <= 64'(coef.p1) * 64'(c_3_reg);
            pp2c_4_reg   <= 64'(coef.p2) * 64'(c_3_reg);
            t0_4_reg     <= t0_next.val;
            t1_4_reg     <= t1_next.val;
            r2_4_reg     <= r2_3_reg;
            sd_reg[3]    <= '{xd0: sd_reg[2].xd0, xd1: sd_reg[2].xd1,
                              clip: sd_reg[2].clip | t0_next.clip | t1_next.clip};
            // stage 5
            r4_5_reg     <= r4_next.val;
            m1_5_reg     <= m1_next.val;
            a1_5_reg     <= a1_next.val;
            a2_5_reg     <= a2_next.val;
            pp2t0_5_reg  <= 64'(coef.p2) * 64'(t0_4_reg);
            pp1t1_5_reg  <= 64'(coef.p1) * 64'(t1_4_reg);
            r2_5_reg     <= r2_4_reg;
            sd_reg[4]    <= '{xd0: sd_reg[3].xd0, xd1: sd_reg[3].xd1,
                              clip: sd_reg[3].clip | r4_next.clip | m1_next.clip
                                    | a1_next.clip | a2_next.clip};
            // stage 6
            pr6_6_reg    <= 64'(r4_5_reg) * 64'(r2_5_reg);
            pk2_6_reg    <= 64'(coef.k2) * 64'(r4_5_reg);
            b0_6_reg     <= b0_next.val;
            b1_6_reg     <= b1_next.val;
            m1_6_reg     <= m1_5_reg;
            a1_6_reg     <= a1_5_reg;
            a2_6_reg     <= a2_5_reg;
            sd_reg[5]    <= '{xd0: sd_reg[4].xd0, xd1: sd_reg[4].xd1,
                              clip: sd_reg[4].clip | b0_next.clip | b1_next.clip};
            // stage 7
            r6_7_reg     <= r6_next.val;
            m2_7_reg     <= m2_next.val;
            dx0_7_reg    <= dx0_next.val;
            dx1_7_reg    <= dx1_next.val;
            m1_7_reg     <= m1_6_reg;
            sd_reg[6]    <= '{xd0: sd_reg[5].xd0, xd1: sd_reg[5].xd1,
                              clip: sd_reg[5].clip | r6_next.clip | m2_next.clip
                                    | dx0_next.clip | dx1_next.clip};
            // stage 8
            pk3_8_reg    <= 64'(coef.k3) * 64'(r6_7_reg);
            n0_8_reg     <= n0_next.val;
            n1_8_reg     <= n1_next.val;
            m1_8_reg     <= m1_7_reg;
            m2_8_reg     <= m2_7_reg;
            sd_reg[7]    <= '{xd0: sd_reg[6].xd0, xd1: sd_reg[6].xd1,
                              clip: sd_reg[6].clip | n0_next.clip | n1_next.clip};
            // stage 9
            m3_9_reg     <= m3_next.val;
            n0_9_reg     <= n0_8_reg;
            n1_9_reg     <= n1_8_reg;
            m1_9_reg     <= m1_8_reg;
            m2_9_reg     <= m2_8_reg;
            sd_reg[8]    <= '{xd0: sd_reg[7].xd0, xd1: sd_reg[7].xd1,
                              clip: sd_reg[7].clip | m3_next.clip};
            // stage 10: radial factor
            kr_10_reg    <= kr_next.val;
            n0_10_reg    <= n0_9_reg;
            n1_10_reg    <= n1_9_reg;
            sd_reg[9]    <= '{xd0: sd_reg[8].xd0, xd1: sd_reg[8].xd1,
                              clip: sd_reg[8].clip | kr_next.clip};
            // carry the distorted point alongside the divider
            dly_reg[0]   <= sd_reg[ITER_LAT-1];
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    lpu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[ITER_LAT-1]),
        .n0        (33'(n0_10_reg)),
        .n1        (33'(n1_10_reg)),
        .d0        (33'(kr_10_reg)),
        .d1        (33'(kr_10_reg)),
        .out_valid (div_valid),
        .q0        (div_q0),
        .q1        (div_q1),
        .clipped   (div_clip)
    );

    assign out_valid   = div_valid;
    assign out_pt.x0   = div_q0;
    assign out_pt.x1   = div_q1;
    assign out_pt.xd0  = dly_reg[DIV_LAT-1].xd0;
    assign out_pt.xd1  = dly_reg[DIV_LAT-1].xd1;
    assign out_pt.clip = dly_reg[DIV_LAT-1].clip | div_clip;

endmodule

>>> src/lpu_out.sv
// Back to pixels: scale by the focal lengths, round, add the principal point, saturate.
module lpu_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [17:0]        focal_x,
    input  logic [17:0]        focal_y,
    input  logic [15:0]        cx,
    input  logic [15:0]        cy,
    input  logic               in_valid,
    input  lpu_pkg::pt_t       in_pt,
    output logic               out_valid,
    output logic signed [17:0] ideal_x,
    output logic signed [17:0] ideal_y,
    output logic               clipped
);
    import lpu_pkg::*;

    logic [OUT_LAT-1:0] v_reg;
    logic signed [63:0] px_reg, py_reg;
    logic signed [24:0] rx_reg, ry_reg;
    logic               c1_reg, c2_reg, c3_reg;
    logic signed [17:0] ox_reg, oy_reg;
    logic signed [63:0] tx_next, ty_next;
    sat18_t             sx_next, sy_next;

    always_comb
    begin
        tx_next = (px_reg + Q_HALF) >>> 28;
        ty_next = (py_reg + Q_HALF) >>> 28;
        sx_next = sat18(rx_reg + $signed({9'b0, cx}));
        sy_next = sat18(ry_reg + $signed({9'b0, cy}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[OUT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 64'(in_pt.x0) * 64'($signed({1'b0, focal_x}));
            py_reg <= 64'(in_pt.x1) * 64'($signed({1'b0, focal_y}));
            c1_reg <= in_pt.clip;
            rx_reg <= 25'(tx_next);
            ry_reg <= 25'(ty_next);
            c2_reg <= c1_reg;
            ox_reg <= sx_next.val;
            oy_reg <= sy_next.val;
            c3_reg <= c2_reg | sx_next.clip | sy_next.clip;
        end
    end

    assign out_valid = v_reg[OUT_LAT-1];
    assign ideal_x   = ox_reg;
    assign ideal_y   = oy_reg;
    assign clipped   = c3_reg;

endmodule

>>> src/lens_point_undistort.sv
// Top level of the lens point undistortion block: config registers, pipeline chain, output.
// Takes one observed point per clock unless a result waits untaken at the output, and returns
// one ideal point per point, in order. The chain is a 34-stage normalizing divider, per iteration ten
// multiply/round stages plus a 34-stage divider (one quotient bit per stage), and three output
// stages; with ITERATIONS = 0 the point passes through one register. The whole pipeline
// advances together: when a result waits untaken in the output register, input ready drops
// and every stage holds. Configuration writes take effect at once and belong in idle time.
module lens_point_undistort #(
    parameter int ITERATIONS = lpu_pkg::LPU_ITERATIONS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [lpu_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [lpu_pkg::CFG_DW-1:0]  cfg_data,
    lpu_in_if.sink                      in_ch,
    lpu_out_if.source                   out_ch
);
    import lpu_pkg::*;

    logic [31:0]        pp_reg;
    logic [17:0]        fx_reg;
    logic [17:0]        fy_reg;
    coef_t              coef_reg;
    logic               en;
    logic               res_valid;
    logic signed [17:0] res_x;
    logic signed [17:0] res_y;
    logic               res_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg   <= '0;
            fx_reg   <= FOCAL_RESET;
            fy_reg   <= FOCAL_RESET;
            coef_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PRINCIPAL: pp_reg      <= cfg_data;
                CFG_FOCAL_X:   fx_reg      <= cfg_data[17:0];
                CFG_FOCAL_Y:   fy_reg      <= cfg_data[17:0];
                CFG_K1:        coef_reg.k1 <= $signed(cfg_data);
                CFG_K2:        coef_reg.k2 <= $signed(cfg_data);
                CFG_K3:        coef_reg.k3 <= $signed(cfg_data);
                CFG_P1:        coef_reg.p1 <= $signed(cfg_data);
                CFG_P2:        coef_reg.p2 <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // advance everything unless the output holds an untaken result
    assign en          = !res_valid || out_ch.ready;
    assign in_ch.ready = en;

    generate
        if (ITERATIONS == 0)
        begin : g_pass
            logic               v_reg;
            logic signed [17:0] x_reg;
            logic signed [17:0] y_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= in_ch.valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg <= $signed({2'b0, in_ch.observed_x});
                    y_reg <= $signed({2'b0, in_ch.observed_y});
                end
            end

            assign res_valid = v_reg;
            assign res_x     = x_reg;
            assign res_y     = y_reg;
            assign res_clip  = 1'b0;
        end
        else
        begin : g_chain
            logic               nv;
            logic signed [31:0] nq0;
            logic signed [31:0] nq1;
            logic               nclip;
            logic               cv [0:ITERATIONS];
            pt_t                cp [0:ITERATIONS];

            // normalize: (observed - principal point) / focal length
            lpu_div u_norm (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (in_ch.valid),
                .n0        ($signed({17'b0, in_ch.observed_x}) - $signed({17'b0, pp_reg[31:16]})),
                .n1        ($signed({17'b0, in_ch.observed_y}) - $signed({17'b0, pp_reg[15:0]})),
                .d0        ($signed({15'b0, fx_reg})),
                .d1        ($signed({15'b0, fy_reg})),
                .out_valid (nv),
                .q0        (nq0),
                .q1        (nq1),
                .clipped   (nclip)
            );

            assign cv[0] = nv;
            assign cp[0] = '{x0: nq0, x1: nq1, xd0: nq0, xd1: nq1, clip: nclip};

            for (genvar i = 0; i < ITERATIONS; i++)
            begin : g_iter
                lpu_iter u_iter (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .coef      (coef_reg),
                    .in_valid  (cv[i]),
                    .in_pt     (cp[i]),
                    .out_valid (cv[i+1]),
                    .out_pt    (cp[i+1])
                );
            end

            lpu_out u_out (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .focal_x   (fx_reg),
                .focal_y   (fy_reg),
                .cx        (pp_reg[31:16]),
                .cy        (pp_reg[15:0]),
                .in_valid  (cv[ITERATIONS]),
                .in_pt     (cp[ITERATIONS]),
                .out_valid (res_valid),
                .ideal_x   (res_x),
                .ideal_y   (res_y),
                .clipped   (res_clip)
            );
        end
    endgenerate

    assign out_ch.valid   = res_valid;
    assign out_ch.ideal_x = res_x;
    assign out_ch.ideal_y = res_y;
    assign out_ch.clipped = res_clip;

    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input held off with no result waiting");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |=> out_ch.valid)
        else $error("result dropped during stall");

    a_new_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(in_ch.ready))
        else $error("result appeared while the pipeline was held");

endmodule

>>> dv/lens_point_undistort_test.sv
// Self-checking bench for the lens point undistortion block: directed table, random phases.
`timescale 1ns / 100ps

module lens_point_undistort_test;
    import lpu_pkg::*;

    localparam int          PIPE_LAT     = 34 + LPU_ITERATIONS * 44 + 3;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          PHASE_POINTS = 175;
    localparam int          RAND_PHASES  = 6;
    localparam logic [7:0]  CFG_SPARE_LO = 8'd8;
    localparam logic [7:0]  CFG_SPARE_HI = 8'd255;
    localparam longint      MAX32        = 64'sd2147483647;
    localparam longint      MIN32        = -64'sd2147483648;
    localparam longint      MAX18        = 64'sd131071;
    localparam longint      MIN18        = -64'sd131072;

    typedef struct {
        logic signed [17:0] ideal_x;
        logic signed [17:0] ideal_y;
        logic               clipped;
    } ideal_pt_t;

    typedef enum int {
        SET_RESET,
        SET_NO_FOCAL,
        SET_RADIAL_ZERO,
        SET_TANGENT,
        SET_SPARE_WRITES
    } dir_setup_t;

    typedef struct {
        dir_setup_t  setup;
        logic [15:0] ox;
        logic [15:0] oy;
        bit          typed;
        ideal_pt_t   res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lpu_in_if  in_ch ();
    lpu_out_if out_ch ();

    lens_point_undistort uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    // shadow registers
    logic [31:0]        sh_pp;
    logic [17:0]        sh_fx;
    logic [17:0]        sh_fy;
    logic signed [31:0] sh_k1, sh_k2, sh_k3, sh_p1, sh_p2;

    ideal_pt_t pending_pts[$];
    int        errors = 0;
    bit        hold_req = 1'b0;
    int        burst_left = 0;

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.observed_x = '0;
        in_ch.observed_y = '0;
        out_ch.ready     = 1'b0;
    end

    function automatic longint fit32(input longint v, inout bit clip);
        if (v > MAX32)
        begin
            clip = 1'b1;
            return MAX32;
        end
        if (v < MIN32)
        begin
            clip = 1'b1;
            return MIN32;
        end
        return v;
    endfunction

    function automatic longint round28(input longint p);
        return (p + 64'sd134217728) >>> 28;
    endfunction

    function automatic longint qmul(input longint a, input longint b, inout bit clip);
        return fit32(round28(a * b), clip);
    endfunction

    function automatic longint qdiv(input longint n, input longint d, inout bit clip);
        longint un, ud, q;
        bit     neg;
        if (d == 0)
        begin
            clip = 1'b1;
            return (n > 0) ? MAX32 : (n < 0) ? MIN32 : 0;
        end
        neg = (n < 0) != (d < 0);
        un  = (n < 0 ? -n : n) << 28;
        ud  = d < 0 ? -d : d;
        q   = (2 * un + ud) / (2 * ud);
        return fit32(neg ? -q : q, clip);
    endfunction

    function automatic longint fit18(input longint v, inout bit clip);
        if (v > MAX18)
        begin
            clip = 1'b1;
            return MAX18;
        end
        if (v < MIN18)
        begin
            clip = 1'b1;
            return MIN18;
        end
        return v;
    endfunction

    function automatic ideal_pt_t undistort(input logic [15:0] ox, input logic [15:0] oy);
        ideal_pt_t r;
        bit        clip;
        longint    cx, cy, xd0, xd1, x0, x1, s0, s1, c, r2, r4, r6, kr, t0, t1;
        longint    dx0, dx1, n0, n1, rx, ry;
        longint    m1, m2, m3, a1, a2, b0, b1;
        clip = 1'b0;
        if (LPU_ITERATIONS == 0)
        begin
            r.ideal_x = $signed({2'b0, ox});
            r.ideal_y = $signed({2'b0, oy});
            r.clipped = 1'b0;
            return r;
        end
        cx   = longint'(sh_pp[31:16]);
        cy   = longint'(sh_pp[15:0]);
        xd0  = qdiv(longint'(ox) - cx, longint'(sh_fx), clip);
        xd1  = qdiv(longint'(oy) - cy, longint'(sh_fy), clip);
        x0   = xd0;
        x1   = xd1;
        for (int i = 0; i < LPU_ITERATIONS; i++)
        begin
            s0  = qmul(x0, x0, clip);
            s1  = qmul(x1, x1, clip);
            c   = qmul(x0, x1, clip);
            r2  = fit32(s0 + s1, clip);
            r4  = qmul(r2, r2, clip);
            r6  = qmul(r4, r2, clip);
            m1  = qmul(sh_k1, r2, clip);
            m2  = qmul(sh_k2, r4, clip);
            m3  = qmul(sh_k3, r6, clip);
            kr  = fit32(64'sd268435456 + m1 + m2 + m3, clip);
            t0  = fit32(r2 + 2 * s0, clip);
            t1  = fit32(r2 + 2 * s1, clip);
            a1  = qmul(sh_p1, c, clip);
            b0  = qmul(sh_p2, t0, clip);
            dx0 = fit32(2 * a1 + b0, clip);
            b1  = qmul(sh_p1, t1, clip);
            a2  = qmul(sh_p2, c, clip);
            dx1 = fit32(b1 + 2 * a2, clip);
            n0  = fit32(xd0 - dx0, clip);
            n1  = fit32(xd1 - dx1, clip);
            x0  = qdiv(n0, kr, clip);
            x1  = qdiv(n1, kr, clip);
        end
        rx = fit18(round28(x0 * longint'(sh_fx)) + cx, clip);
        ry = fit18(round28(x1 * longint'(sh_fy)) + cy, clip);
        r.ideal_x = rx[17:0];
        r.ideal_y = ry[17:0];
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_PRINCIPAL: sh_pp = data;
            CFG_FOCAL_X:   sh_fx = data[17:0];
            CFG_FOCAL_Y:   sh_fy = data[17:0];
            CFG_K1:        sh_k1 = data;
            CFG_K2:        sh_k2 = data;
            CFG_K3:        sh_k3 = data;
            CFG_P1:        sh_p1 = data;
            CFG_P2:        sh_p2 = data;
            default:       ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] pp, input logic [17:0] fx, input logic [17:0] fy,
                             input logic [31:0] k1, input logic [31:0] k2,
                             input logic [31:0] k3, input logic [31:0] p1,
                             input logic [31:0] p2);
        write_reg(CFG_PRINCIPAL, pp);
        write_reg(CFG_FOCAL_X, {14'd0, fx});
        write_reg(CFG_FOCAL_Y, {14'd0, fy});
        write_reg(CFG_K1, k1);
        write_reg(CFG_K2, k2);
        write_reg(CFG_K3, k3);
        write_reg(CFG_P1, p1);
        write_reg(CFG_P2, p2);
    endtask

    // request one point; predict on acceptance unless the row carries a typed result
    task automatic send_point(input logic [15:0] ox, input logic [15:0] oy,
                              input bit typed, input ideal_pt_t res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid      = 1'b1;
        in_ch.observed_x = ox;
        in_ch.observed_y = oy;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_pts.push_back(typed ? res : undistort(ox, oy));
    endtask

    // drop valid, wait out the results, then let the pipeline settle
    task automatic drain;
        @(negedge clk);
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 10) @(negedge clk);
    endtask

    task automatic setup_directed(input dir_setup_t s);
        case (s)
            SET_RESET:        ;
            SET_NO_FOCAL:     write_all({16'h1234, 16'h5678}, '0, '0, 0, 0, 0, 0, 0);
            SET_RADIAL_ZERO:  write_all(0, FOCAL_RESET, FOCAL_RESET,
                                        -32'sd268435456, 0, 0, 0, 0);
            SET_TANGENT:      write_all({16'd10240, 16'd5760}, 18'd12800, 18'd12000,
                                        -32'sd53687091, 32'sd13421772, -32'sd2684354,
                                        32'sd268435, -32'sd536870);
            SET_SPARE_WRITES:
            begin
                write_all(0, FOCAL_RESET, FOCAL_RESET, 0, 0, 0, 0, 0);
                write_reg(CFG_SPARE_LO, 32'hdeadbeef);
                write_reg(CFG_SPARE_HI, 32'h00000001);
                write_reg(CFG_FOCAL_X, 32'hfffc4000);
            end
            default:          ;
        endcase
    endtask

    dir_row_t dir_rows[] = '{
        '{SET_RESET,        16'd0,     16'd0,     1'b1, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RESET,        16'd16,    16'd32,    1'b1, '{18'sd16,    18'sd32,    1'b0}},
        '{SET_RESET,        16'd8192,  16'd8192,  1'b1, '{18'sd8192,  18'sd8192,  1'b0}},
        '{SET_RESET,        16'd12000, 16'd0,     1'b1, '{18'sd12000, 18'sd0,     1'b0}},
        '{SET_RESET,        16'd65535, 16'd65535, 1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RESET,        16'd0,     16'd65535, 1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RESET,        16'd65535, 16'd0,     1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_NO_FOCAL,     16'd0,     16'd0,     1'b1, '{18'sd4660,  18'sd22136, 1'b1}},
        '{SET_NO_FOCAL,     16'h1234,  16'h5678,  1'b1, '{18'sd4660,  18'sd22136, 1'b1}},
        '{SET_NO_FOCAL,     16'd65535, 16'd65535, 1'b1, '{18'sd4660,  18'sd22136, 1'b1}},
        '{SET_RADIAL_ZERO,  16'd16384, 16'd0,     1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RADIAL_ZERO,  16'd0,     16'd16384, 1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RADIAL_ZERO,  16'd4096,  16'd4096,  1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_RADIAL_ZERO,  16'd0,     16'd0,     1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_TANGENT,      16'd10240, 16'd5760,  1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_TANGENT,      16'd0,     16'd0,     1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_TANGENT,      16'd20480, 16'd11520, 1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_TANGENT,      16'd65535, 16'd65535, 1'b0, '{18'sd0,     18'sd0,     1'b0}},
        '{SET_SPARE_WRITES, 16'd16,    16'd32,    1'b1, '{18'sd16,    18'sd32,    1'b0}},
        '{SET_SPARE_WRITES, 16'd8192,  16'd100,   1'b1, '{18'sd8192,  18'sd100,   1'b0}}
    };

    // receiver: changing stall patterns, one long hold-off on request
    initial
    begin
        int mode, tick, k;
        mode = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                for (k = 1; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (tick % 256 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = $urandom_range(0, 1);
                    default: out_ch.ready = (tick % 4 == 0);
                endcase
                tick++;
            end
        end
    end

    always @(posedge clk)
    begin
        ideal_pt_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_pts.size() == 0)
            begin
                report_mismatch("result with no request pending", 1, 0);
            end
            else
            begin
                want = pending_pts.pop_front();
                if (out_ch.ideal_x !== want.ideal_x)
                    report_mismatch("ideal_x", out_ch.ideal_x, want.ideal_x);
                if (out_ch.ideal_y !== want.ideal_y)
                    report_mismatch("ideal_y", out_ch.ideal_y, want.ideal_y);
                if (out_ch.clipped !== want.clipped)
                    report_mismatch("clipped", out_ch.clipped, want.clipped);
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        dir_setup_t  cur;
        logic [15:0] ox, oy, cx, cy;
        ideal_pt_t   none;
        none  = '{18'sd0, 18'sd0, 1'b0};
        sh_pp = '0;
        sh_fx = FOCAL_RESET;
        sh_fy = FOCAL_RESET;
        sh_k1 = '0;
        sh_k2 = '0;
        sh_k3 = '0;
        sh_p1 = '0;
        sh_p2 = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        cur = SET_RESET;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].setup != cur)
            begin
                drain();
                cur = dir_rows[i].setup;
                setup_directed(cur);
            end
            send_point(dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: write_all({16'd10240, 16'd5760}, 18'd12800, 18'd12800, -32'sd53687091,
                             32'sd8053063, -32'sd1342177, 32'sd268435, -32'sd402653);
                1: write_all(32'hffffffff, 18'h3ffff, 18'h3ffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                2: write_all(32'h00000000, 18'd1, 18'd1, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
                3: write_all($urandom, 18'($urandom_range(1, 262143)),
                             18'($urandom_range(1, 262143)),
                             $signed($urandom) >>> 4, $signed($urandom) >>> 6,
                             $signed($urandom) >>> 8, $signed($urandom) >>> 8,
                             $signed($urandom) >>> 8);
                default: write_all($urandom, 18'($urandom), 18'($urandom), $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            cx = sh_pp[31:16];
            cy = sh_pp[15:0];
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                // let the first result reach the held output, then keep offering
                if (ph == 0 && n == 1)
                begin
                    @(negedge clk);
                    in_ch.valid = 1'b0;
                    burst_left  = 0;
                    repeat (PIPE_LAT + 20) @(negedge clk);
                end
                if ($urandom_range(0, 9) < 3)
                begin
                    ox = 16'($urandom);
                    oy = 16'($urandom);
                end
                else
                begin
                    ox = cx + 16'($urandom_range(0, 16383)) - 16'd8192;
                    oy = cy + 16'($urandom_range(0, 16383)) - 16'd8192;
                end
                send_point(ox, oy, 1'b0, none);
            end
        end

        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
